[rtl/edf_pkg.sv]
package edf_pkg;

   localparam int MAX_TASKS_DEF  = 16;
   localparam int TIME_BITS_DEF  = 32;
   localparam int COUNT_BITS_DEF = 16;

   localparam logic [2:0] REQ_TICK     = 3'd0;
   localparam logic [2:0] REQ_PLAIN    = 3'd1;
   localparam logic [2:0] REQ_REALTIME = 3'd2;
   localparam logic [2:0] REQ_PERIODIC = 3'd3;
   localparam logic [2:0] REQ_PREEMPT  = 3'd4;
   localparam logic [2:0] REQ_FINISH   = 3'd5;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_SLOT_BUSY  = 2'd1;
   localparam logic [1:0] STATUS_NO_CURRENT = 2'd2;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_RT,
      KIND_PERIODIC
   } kind_type;

   typedef enum logic [1:0] {
      PLACE_FIFO,
      PLACE_WAIT,
      PLACE_READY,
      PLACE_RUN
   } place_type;

   // OP_MOVE keeps the entry order dense (later entries close the gap),
   // OP_APPEND places a task that held no order position at the tail.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_CREATE,
      OP_MOVE,
      OP_APPEND,
      OP_PERIODIC,
      OP_RETIRE,
      OP_DISPATCH
   } op_type;

   typedef struct packed {
      op_type    op;
      place_type place;
      kind_type  kind;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MIGRATE,
      ST_CURRENT,
      ST_DISPATCH,
      ST_RESP
   } state_type;

endpackage

[rtl/edf_cell.sv]
module edf_cell #(
   parameter int INDEX     = 0,
   parameter int SLOT_W    = 4,
   parameter int STAMP_W   = 4,
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  edf_pkg::cmd_type     cmd,
   input  logic [SLOT_W-1:0]    cmd_slot,
   input  logic [TIME_BITS-1:0] cmd_arr,
   input  logic [TIME_BITS-1:0] cmd_dl,
   input  logic [TIME_BITS-1:0] cmd_per,
   input  logic [TIME_BITS-1:0] cmd_now,
   input  logic [STAMP_W-1:0]   cmd_ref,
   input  logic [STAMP_W-1:0]   cmd_new,
   input  edf_pkg::place_type   mode,
   input  logic                 tin_v,
   input  logic [SLOT_W-1:0]    tin_slot,
   input  logic [TIME_BITS-1:0] tin_arr,
   input  logic [TIME_BITS-1:0] tin_dl,
   input  logic [STAMP_W-1:0]   tin_stamp,
   input  edf_pkg::kind_type    tin_kind,
   output logic                 tout_v,
   output logic [SLOT_W-1:0]    tout_slot,
   output logic [TIME_BITS-1:0] tout_arr,
   output logic [TIME_BITS-1:0] tout_dl,
   output logic [STAMP_W-1:0]   tout_stamp,
   output edf_pkg::kind_type    tout_kind,
   output logic                 valid_o
);
   import edf_pkg::*;

   logic                 valid_ff, valid_in;
   kind_type             kind_ff, kind_in;
   logic [TIME_BITS-1:0] arr_ff, arr_in;
   logic [TIME_BITS-1:0] dl_ff, dl_in;
   logic [TIME_BITS-1:0] per_ff, per_in;
   place_type            place_ff, place_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;

   logic                 tok_v_ff, tok_v_in;
   logic [SLOT_W-1:0]    tok_slot_ff, tok_slot_in;
   logic [TIME_BITS-1:0] tok_arr_ff, tok_arr_in;
   logic [TIME_BITS-1:0] tok_dl_ff, tok_dl_in;
   logic [STAMP_W-1:0]   tok_stamp_ff, tok_stamp_in;
   kind_type             tok_kind_ff, tok_kind_in;

   logic                 hit, shrink, elig, take;
   logic [TIME_BITS-1:0] arr_adv, key_mine, key_tin;

   assign hit     = (cmd_slot == SLOT_W'(INDEX));
   assign shrink  = valid_ff && !hit && (stamp_ff > cmd_ref) &&
                    ((cmd.op == OP_MOVE) || (cmd.op == OP_DISPATCH));
   assign arr_adv = arr_ff + per_ff;

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      arr_in   = arr_ff;
      dl_in    = dl_ff;
      per_in   = per_ff;
      place_in = place_ff;
      stamp_in = stamp_ff;
      if (shrink) begin
         stamp_in = stamp_ff - 1'b1;
      end
      if (hit) begin
         case (cmd.op)
            OP_CREATE: begin
               valid_in = 1'b1;
               kind_in  = cmd.kind;
               arr_in   = cmd_arr;
               dl_in    = cmd_dl;
               per_in   = cmd_per;
               place_in = cmd.place;
               stamp_in = cmd_new;
            end
            OP_MOVE, OP_APPEND: begin
               place_in = cmd.place;
               stamp_in = cmd_new;
            end
            OP_PERIODIC: begin
               arr_in   = arr_adv;
               dl_in    = dl_ff + per_ff;
               place_in = (cmd_now > arr_adv) ? PLACE_READY : PLACE_WAIT;
               stamp_in = cmd_new;
            end
            OP_RETIRE: begin
               valid_in = 1'b0;
            end
            OP_DISPATCH: begin
               place_in = PLACE_RUN;
            end
            default: ;
         endcase
      end
   end

   // search token: keep the better of the incoming candidate and this slot
   assign elig     = valid_ff && (place_ff == mode);
   assign key_mine = (mode == PLACE_READY) ? dl_ff :
                     (mode == PLACE_WAIT)  ? arr_ff : '0;
   assign key_tin  = (mode == PLACE_READY) ? tin_dl :
                     (mode == PLACE_WAIT)  ? tin_arr : '0;
   assign take     = elig && (!tin_v || (key_mine < key_tin) ||
                     ((key_mine == key_tin) && (stamp_ff < tin_stamp)));

   always_comb begin
      if (take) begin
         tok_v_in     = 1'b1;
         tok_slot_in  = SLOT_W'(INDEX);
         tok_arr_in   = arr_ff;
         tok_dl_in    = dl_ff;
         tok_stamp_in = stamp_ff;
         tok_kind_in  = kind_ff;
      end else begin
         tok_v_in     = tin_v;
         tok_slot_in  = tin_slot;
         tok_arr_in   = tin_arr;
         tok_dl_in    = tin_dl;
         tok_stamp_in = tin_stamp;
         tok_kind_in  = tin_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_v_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_v_ff <= tok_v_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      arr_ff       <= arr_in;
      dl_ff        <= dl_in;
      per_ff       <= per_in;
      place_ff     <= place_in;
      stamp_ff     <= stamp_in;
      tok_slot_ff  <= tok_slot_in;
      tok_arr_ff   <= tok_arr_in;
      tok_dl_ff    <= tok_dl_in;
      tok_stamp_ff <= tok_stamp_in;
      tok_kind_ff  <= tok_kind_in;
   end

   assign tout_v     = tok_v_ff;
   assign tout_slot  = tok_slot_ff;
   assign tout_arr   = tok_arr_ff;
   assign tout_dl    = tok_dl_ff;
   assign tout_stamp = tok_stamp_ff;
   assign tout_kind  = tok_kind_ff;
   assign valid_o    = valid_ff;

endmodule

[rtl/edf_task_scheduler_unit.sv]
// EDF task scheduler. Each task slot lives in a cell; queue heads are found
// by a search token that walks the cell row one cell per clock. Preempt and
// finish first search the wait queue anew for each waiting task that becomes
// ready, then look at one to three queues (ready, FIFO, wait) for the
// dispatch. One request is in work at a time; the next is taken while the
// previous result still waits on rsp_stall.
module edf_task_scheduler_unit #(
   parameter int MAX_TASKS  = edf_pkg::MAX_TASKS_DEF,
   parameter int TIME_BITS  = edf_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = edf_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_task_slot,
   input  logic [31:0] req_start_ms,
   input  logic [31:0] req_rel_deadline_ms,
   input  logic [31:0] req_period_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_run_valid,
   output logic [3:0]  rsp_run_slot,
   output logic        rsp_must_wait,
   output logic [15:0] rsp_met_count,
   output logic [15:0] rsp_miss_count,
   output logic [1:0]  rsp_status
);
   import edf_pkg::*;

   localparam int SLOT_W  = $clog2(MAX_TASKS);
   localparam int STAMP_W = $clog2(MAX_TASKS);
   localparam int CNT_W   = $clog2(MAX_TASKS + 1);

   state_type            state_ff, state_in;
   logic [2:0]           q_type_ff, q_type_in;
   logic [3:0]           q_slot_ff, q_slot_in;
   logic [TIME_BITS-1:0] q_start_ff, q_start_in;
   logic [TIME_BITS-1:0] q_rel_ff, q_rel_in;
   logic [TIME_BITS-1:0] q_per_ff, q_per_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 cur_v_ff, cur_v_in;
   logic [SLOT_W-1:0]    cur_slot_ff, cur_slot_in;
   kind_type             cur_kind_ff, cur_kind_in;
   logic [TIME_BITS-1:0] cur_dl_ff, cur_dl_in;
   logic [CNT_W-1:0]     ord_cnt_ff, ord_cnt_in;
   logic [COUNT_BITS-1:0] met_ff, met_in;
   logic [COUNT_BITS-1:0] miss_ff, miss_in;
   place_type            mode_ff, mode_in;
   logic [CNT_W-1:0]     scnt_ff, scnt_in;
   logic                 r_run_v_ff, r_run_v_in;
   logic [3:0]           r_slot_ff, r_slot_in;
   logic                 r_wait_ff, r_wait_in;
   logic [1:0]           r_status_ff, r_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_run_v_ff, rsp_run_v_in;
   logic [3:0]           rsp_slot_ff, rsp_slot_in;
   logic                 rsp_wait_ff, rsp_wait_in;
   logic [15:0]          rsp_met_ff, rsp_met_in;
   logic [15:0]          rsp_miss_ff, rsp_miss_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   cmd_type              cmd;
   logic [SLOT_W-1:0]    c_slot;
   logic [TIME_BITS-1:0] c_arr, c_dl, c_per;
   logic [STAMP_W-1:0]   c_ref, c_new;

   logic                 tin_v     [MAX_TASKS];
   logic [SLOT_W-1:0]    tin_slot  [MAX_TASKS];
   logic [TIME_BITS-1:0] tin_arr   [MAX_TASKS];
   logic [TIME_BITS-1:0] tin_dl    [MAX_TASKS];
   logic [STAMP_W-1:0]   tin_stamp [MAX_TASKS];
   kind_type             tin_kind  [MAX_TASKS];
   logic                 tok_v     [MAX_TASKS];
   logic [SLOT_W-1:0]    tok_slot  [MAX_TASKS];
   logic [TIME_BITS-1:0] tok_arr   [MAX_TASKS];
   logic [TIME_BITS-1:0] tok_dl    [MAX_TASKS];
   logic [STAMP_W-1:0]   tok_stamp [MAX_TASKS];
   kind_type             tok_kind  [MAX_TASKS];
   logic [MAX_TASKS-1:0] slot_vec;

   logic                 e_v;
   logic [SLOT_W-1:0]    e_slot;
   logic [TIME_BITS-1:0] e_arr, e_dl;
   logic [STAMP_W-1:0]   e_stamp;
   kind_type             e_kind;
   logic                 srch_done, mig_go, slot_ok, create_ok, out_free;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign tin_v[gi]     = 1'b0;
            assign tin_slot[gi]  = '0;
            assign tin_arr[gi]   = '0;
            assign tin_dl[gi]    = '0;
            assign tin_stamp[gi] = '0;
            assign tin_kind[gi]  = KIND_PLAIN;
         end else begin : g_link
            assign tin_v[gi]     = tok_v[gi-1];
            assign tin_slot[gi]  = tok_slot[gi-1];
            assign tin_arr[gi]   = tok_arr[gi-1];
            assign tin_dl[gi]    = tok_dl[gi-1];
            assign tin_stamp[gi] = tok_stamp[gi-1];
            assign tin_kind[gi]  = tok_kind[gi-1];
         end
         edf_cell #(
            .INDEX     (gi),
            .SLOT_W    (SLOT_W),
            .STAMP_W   (STAMP_W),
            .TIME_BITS (TIME_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .cmd_slot   (c_slot),
            .cmd_arr    (c_arr),
            .cmd_dl     (c_dl),
            .cmd_per    (c_per),
            .cmd_now    (now_ff),
            .cmd_ref    (c_ref),
            .cmd_new    (c_new),
            .mode       (mode_ff),
            .tin_v      (tin_v[gi]),
            .tin_slot   (tin_slot[gi]),
            .tin_arr    (tin_arr[gi]),
            .tin_dl     (tin_dl[gi]),
            .tin_stamp  (tin_stamp[gi]),
            .tin_kind   (tin_kind[gi]),
            .tout_v     (tok_v[gi]),
            .tout_slot  (tok_slot[gi]),
            .tout_arr   (tok_arr[gi]),
            .tout_dl    (tok_dl[gi]),
            .tout_stamp (tok_stamp[gi]),
            .tout_kind  (tok_kind[gi]),
            .valid_o    (slot_vec[gi])
         );
      end
   endgenerate

   assign e_v     = tok_v[MAX_TASKS-1];
   assign e_slot  = tok_slot[MAX_TASKS-1];
   assign e_arr   = tok_arr[MAX_TASKS-1];
   assign e_dl    = tok_dl[MAX_TASKS-1];
   assign e_stamp = tok_stamp[MAX_TASKS-1];
   assign e_kind  = tok_kind[MAX_TASKS-1];

   // the search is done when the token has reached the last cell
   assign srch_done = (scnt_ff == CNT_W'(MAX_TASKS));
   assign mig_go    = e_v && (now_ff > e_arr);
   assign slot_ok   = (32'(q_slot_ff) < 32'(MAX_TASKS));
   assign create_ok = slot_ok && !slot_vec[SLOT_W'(q_slot_ff)];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if ((q_type_ff == REQ_PREEMPT) || (q_type_ff == REQ_FINISH)) begin
               state_in = ST_MIGRATE;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_MIGRATE: begin
            if (srch_done && !mig_go) state_in = ST_CURRENT;
         end
         ST_CURRENT: state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (srch_done && (e_v || (mode_ff == PLACE_WAIT))) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_type_in   = q_type_ff;
      q_slot_in   = q_slot_ff;
      q_start_in  = q_start_ff;
      q_rel_in    = q_rel_ff;
      q_per_in    = q_per_ff;
      now_in      = now_ff;
      cur_v_in    = cur_v_ff;
      cur_slot_in = cur_slot_ff;
      cur_kind_in = cur_kind_ff;
      cur_dl_in   = cur_dl_ff;
      ord_cnt_in  = ord_cnt_ff;
      met_in      = met_ff;
      miss_in     = miss_ff;
      mode_in     = mode_ff;
      scnt_in     = scnt_ff + 1'b1;
      r_run_v_in  = r_run_v_ff;
      r_slot_in   = r_slot_ff;
      r_wait_in   = r_wait_ff;
      r_status_in = r_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_run_v_in  = rsp_run_v_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_met_in    = rsp_met_ff;
      rsp_miss_in   = rsp_miss_ff;
      rsp_status_in = rsp_status_ff;
      cmd.op    = OP_NONE;
      cmd.place = PLACE_FIFO;
      cmd.kind  = KIND_PLAIN;
      c_slot    = '0;
      c_arr     = '0;
      c_dl      = '0;
      c_per     = '0;
      c_ref     = '0;
      c_new     = STAMP_W'(ord_cnt_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               q_type_in   = req_type;
               q_slot_in   = req_task_slot;
               q_start_in  = TIME_BITS'(req_start_ms);
               q_rel_in    = TIME_BITS'(req_rel_deadline_ms);
               q_per_in    = TIME_BITS'(req_period_ms);
               r_run_v_in  = 1'b0;
               r_slot_in   = '0;
               r_wait_in   = 1'b0;
               r_status_in = STATUS_OK;
            end
         end
         ST_EXEC: begin
            case (q_type_ff)
               REQ_TICK: now_in = now_ff + 1'b1;
               REQ_PLAIN, REQ_REALTIME, REQ_PERIODIC: begin
                  if (create_ok) begin
                     cmd.op     = OP_CREATE;
                     c_slot     = SLOT_W'(q_slot_ff);
                     ord_cnt_in = ord_cnt_ff + 1'b1;
                     if (q_type_ff == REQ_PLAIN) begin
                        cmd.place = PLACE_FIFO;
                        cmd.kind  = KIND_PLAIN;
                     end else begin
                        cmd.place = PLACE_WAIT;
                        cmd.kind  = (q_type_ff == REQ_REALTIME) ? KIND_RT : KIND_PERIODIC;
                        c_arr     = q_start_ff;
                        c_dl      = q_start_ff + q_rel_ff;
                        c_per     = (q_type_ff == REQ_PERIODIC) ? q_per_ff : '0;
                     end
                  end else begin
                     r_status_in = STATUS_SLOT_BUSY;
                  end
               end
               REQ_PREEMPT, REQ_FINISH: begin
                  mode_in = PLACE_WAIT;
                  scnt_in = '0;
               end
               default: ;
            endcase
         end
         ST_MIGRATE: begin
            if (srch_done && mig_go) begin
               cmd.op    = OP_MOVE;
               cmd.place = PLACE_READY;
               c_slot    = e_slot;
               c_ref     = e_stamp;
               c_new     = STAMP_W'(ord_cnt_ff - 1'b1);
               scnt_in   = '0;
            end
         end
         ST_CURRENT: begin
            mode_in  = PLACE_READY;
            scnt_in  = '0;
            cur_v_in = 1'b0;
            c_slot   = cur_slot_ff;
            if (!cur_v_ff) begin
               r_status_in = STATUS_NO_CURRENT;
            end else if (q_type_ff == REQ_PREEMPT) begin
               cmd.op     = OP_APPEND;
               cmd.place  = (cur_kind_ff == KIND_PLAIN) ? PLACE_FIFO : PLACE_READY;
               ord_cnt_in = ord_cnt_ff + 1'b1;
            end else begin
               if (cur_kind_ff != KIND_PLAIN) begin
                  if (now_ff <= cur_dl_ff) begin
                     if (met_ff != '1) met_in = met_ff + 1'b1;
                  end else begin
                     if (miss_ff != '1) miss_in = miss_ff + 1'b1;
                  end
               end
               if (cur_kind_ff == KIND_PERIODIC) begin
                  cmd.op     = OP_PERIODIC;
                  ord_cnt_in = ord_cnt_ff + 1'b1;
               end else begin
                  cmd.op = OP_RETIRE;
               end
            end
         end
         ST_DISPATCH: begin
            if (srch_done) begin
               if (e_v) begin
                  // the running task leaves the entry order
                  cmd.op      = OP_DISPATCH;
                  c_slot      = e_slot;
                  c_ref       = e_stamp;
                  ord_cnt_in  = ord_cnt_ff - 1'b1;
                  cur_v_in    = 1'b1;
                  cur_slot_in = e_slot;
                  cur_kind_in = e_kind;
                  cur_dl_in   = e_dl;
                  r_run_v_in  = 1'b1;
                  r_slot_in   = 4'(e_slot);
                  r_wait_in   = (mode_ff == PLACE_WAIT) && (e_arr > now_ff);
               end else if (mode_ff == PLACE_READY) begin
                  mode_in = PLACE_FIFO;
                  scnt_in = '0;
               end else if (mode_ff == PLACE_FIFO) begin
                  mode_in = PLACE_WAIT;
                  scnt_in = '0;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_run_v_in  = r_run_v_ff;
               rsp_slot_in   = r_slot_ff;
               rsp_wait_in   = r_wait_ff;
               rsp_met_in    = 16'(met_ff);
               rsp_miss_in   = 16'(miss_ff);
               rsp_status_in = r_status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         cur_v_ff     <= 1'b0;
         ord_cnt_ff   <= '0;
         met_ff       <= '0;
         miss_ff      <= '0;
         mode_ff      <= PLACE_FIFO;
         scnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         cur_v_ff     <= cur_v_in;
         ord_cnt_ff   <= ord_cnt_in;
         met_ff       <= met_in;
         miss_ff      <= miss_in;
         mode_ff      <= mode_in;
         scnt_ff      <= scnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_type_ff     <= q_type_in;
      q_slot_ff     <= q_slot_in;
      q_start_ff    <= q_start_in;
      q_rel_ff      <= q_rel_in;
      q_per_ff      <= q_per_in;
      cur_slot_ff   <= cur_slot_in;
      cur_kind_ff   <= cur_kind_in;
      cur_dl_ff     <= cur_dl_in;
      r_run_v_ff    <= r_run_v_in;
      r_slot_ff     <= r_slot_in;
      r_wait_ff     <= r_wait_in;
      r_status_ff   <= r_status_in;
      rsp_run_v_ff  <= rsp_run_v_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_met_ff    <= rsp_met_in;
      rsp_miss_ff   <= rsp_miss_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_run_valid  = rsp_run_v_ff;
   assign rsp_run_slot   = rsp_slot_ff;
   assign rsp_must_wait  = rsp_wait_ff;
   assign rsp_met_count  = rsp_met_ff;
   assign rsp_miss_count = rsp_miss_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
